/* src/nras_pkg.sv */
// Shared types, constants and reply-byte lookup for the nibble register access slave.
// Depends on nothing; every other file of the block imports it.
package nras_pkg;

    localparam int ADDR_W = 5;
    localparam int WORD_W = 16;
    localparam int IDX_W  = 5;

    localparam logic [7:0] CMD_FLAG = 8'h80;
    localparam logic [7:0] LOG_HEAD = 8'hA0;
    localparam logic [7:0] LOG_TAIL = 8'h00;

    localparam logic [8*13-1:0] READ_TEXT  = "Read : finish";
    localparam logic [8*14-1:0] WRITE_TEXT = "Write : finish";

    // Index of the final byte of each reply run.
    localparam logic [IDX_W-1:0] READ_LAST  = 5'd19;
    localparam logic [IDX_W-1:0] WRITE_LAST = 5'd15;

    typedef enum logic
    {
        JOB_READ,
        JOB_WRITE_LOG
    } job_kind_t;

    typedef struct packed
    {
        job_kind_t           kind;
        logic [ADDR_W-1:0]   addr;
        logic [WORD_W-1:0]   word;
    } job_t;

    function automatic logic [IDX_W-1:0] last_index(input job_kind_t kind);
        logic [IDX_W-1:0] r;
        r = (kind == JOB_READ) ? READ_LAST : WRITE_LAST;
        return r;
    endfunction

    // Byte number idx of the reply run that job j produces.
    function automatic logic [7:0] reply_byte(input job_t j, input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        int         k;
        b = LOG_TAIL;
        k = int'(idx);
        if (j.kind == JOB_READ)
        begin
            if (k == 0)
                b = CMD_FLAG | {3'b000, j.addr};
            else if (k <= 4)
                b = {4'h0, j.word[4*(4-k) +: 4]};
            else if (k == 5)
                b = LOG_HEAD;
            else if (k <= 18)
                b = READ_TEXT[8*(18-k) +: 8];
            else
                b = LOG_TAIL;
        end
        else
        begin
            if (k == 0)
                b = LOG_HEAD;
            else if (k <= 14)
                b = WRITE_TEXT[8*(14-k) +: 8];
            else
                b = LOG_TAIL;
        end
        return b;
    endfunction

endpackage

/* src/nibble_register_access_slave.sv */
// Top level of the nibble register access slave: front, job queue and back.
// Depends on nras_pkg, nras_front, nras_queue and nras_back.
//
// Usage:
//   Input channel (in_valid / in_ready / rx_byte) carries received serial bytes,
//   one byte per transfer. A command byte (bit7 set) latches an address; with
//   bit6 set it starts a write, else it requests a read. Data bytes (bit7 clear)
//   supply nibbles; the fourth one writes the 16-bit word.
//   Output channel (out_valid / out_ready / tx_byte / last) carries reply bytes,
//   one per transfer; last marks the final byte of the run one input caused.
//   A read gives 20 bytes, a completing data byte 16, other bytes none.
// Path: a job from an input transfer is registered in the job queue; its first reply
//   byte is then loaded into the output register once the back part is free.
// Throughput: the back part sends one byte per cycle while out_ready is high, so a read
//   occupies it for 20 bytes and a write log for 16; the front takes one byte per cycle
//   while the two-entry job queue has room, and stalls only when it is full.
// Reset: the word store, latched address, nibble count and held nibbles clear
//   at once; the queue and output register empty.
// Receiver stall: the output register holds its byte until out_ready; jobs
//   pile up in the queue and then in_ready drops.
module nibble_register_access_slave
    import nras_pkg::*;
#(
    parameter int STORE_DEPTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] tx_byte,
    output logic       last
);

    logic accept;
    logic push;
    job_t push_job;
    logic pop;
    job_t head;
    logic q_empty;
    logic q_full;

    // Every byte, even one that makes no job, waits for queue room so that
    // jobs and store updates always stay in arrival order.
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    nras_front #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .rx_byte  (rx_byte),
        .push     (push),
        .push_job (push_job)
    );

    nras_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    nras_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tx_byte   (tx_byte),
        .last      (last)
    );

endmodule

/* src/nras_front.sv */
// Front part: accepts received bytes, keeps the word store and the nibble
// collection state, and posts reply jobs. Depends on nras_pkg.
module nras_front
    import nras_pkg::*;
#(
    parameter int STORE_DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  rx_byte,
    output logic        push,
    output job_t        push_job
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [ADDR_W:0] DEPTH_L = (ADDR_W + 1)'(STORE_DEPTH);

    logic [WORD_W-1:0] store_reg [STORE_DEPTH];
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic [11:0]       held_reg;
    logic [11:0]       held_next;

    logic              is_cmd;
    logic              is_write_cmd;
    logic [ADDR_W-1:0] cmd_addr;
    logic              rd_in_range;
    logic              wr_in_range;
    logic [WORD_W-1:0] rd_word;
    logic              store_we;
    logic [WORD_W-1:0] wr_word;

    assign is_cmd       = rx_byte[7];
    assign is_write_cmd = rx_byte[6];
    assign cmd_addr     = rx_byte[ADDR_W-1:0];
    assign rd_in_range  = {1'b0, cmd_addr} < DEPTH_L;
    assign wr_in_range  = {1'b0, addr_reg} < DEPTH_L;
    assign rd_word      = rd_in_range ? store_reg[cmd_addr[AW-1:0]] : '0;
    assign wr_word      = {held_reg, rx_byte[3:0]};

    always_comb
    begin
        addr_next  = addr_reg;
        count_next = count_reg;
        held_next  = held_reg;
        store_we   = 1'b0;
        push       = 1'b0;
        push_job   = '{kind: JOB_WRITE_LOG, addr: cmd_addr, word: rd_word};
        if (accept)
        begin
            if (is_cmd)
            begin
                addr_next = cmd_addr;
                if (is_write_cmd)
                    count_next = 2'd0;
                else
                begin
                    push          = 1'b1;
                    push_job.kind = JOB_READ;
                end
            end
            else if (count_reg != 2'd3)
            begin
                held_next  = {held_reg[7:0], rx_byte[3:0]};
                count_next = count_reg + 2'd1;
            end
            else
            begin
                store_we   = wr_in_range;
                count_next = 2'd0;
                held_next  = '0;
                push       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg  <= '0;
            count_reg <= '0;
            held_reg  <= '0;
            for (int i = 0; i < STORE_DEPTH; i++)
                store_reg[i] <= '0;
        end
        else
        begin
            addr_reg  <= addr_next;
            count_reg <= count_next;
            held_reg  <= held_next;
            if (store_we)
                store_reg[addr_reg[AW-1:0]] <= wr_word;
        end
    end

endmodule

/* src/nras_queue.sv */
// Two-entry job queue between the front and back parts.
// Depends on nras_pkg for the job type.
module nras_queue
    import nras_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic empty,
    output logic full
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue popped while empty");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue pushed while full");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 2'd2)
        else $error("queue count out of range");
`endif

endmodule

/* src/nras_back.sv */
// Back part: walks the job at the queue head byte by byte into the output register.
// Depends on nras_pkg for the job type and the reply-byte lookup.
module nras_back
    import nras_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  job_t       head,
    input  logic       q_empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] tx_byte,
    output logic       last
);

    logic [IDX_W-1:0] idx_reg;
    logic             out_valid_reg;
    logic [7:0]       tx_byte_reg;
    logic             last_reg;
    logic             load;
    logic             at_last;

    assign load      = !q_empty && (!out_valid_reg || out_ready);
    assign at_last   = (idx_reg == last_index(head.kind));
    assign pop       = load && at_last;
    assign out_valid = out_valid_reg;
    assign tx_byte   = tx_byte_reg;
    assign last      = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= at_last ? '0 : idx_reg + 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tx_byte_reg <= reply_byte(head, idx_reg);
            last_reg    <= at_last;
        end
    end

`ifndef SYNTHESIS
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n) idx_reg <= READ_LAST)
        else $error("reply index out of range");
    a_wrap: assert property (@(posedge clk) disable iff (!rst_n) pop |=> idx_reg == '0)
        else $error("reply index did not wrap after the final byte");
    a_job_held: assert property (@(posedge clk) disable iff (!rst_n) idx_reg != '0 |-> !q_empty)
        else $error("job left the queue in the middle of its reply");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for nibble_register_access_slave: byte streams go in through the
// input handshake, and every reply byte is checked against a shadow copy of the word store.
// Depends only on the block's RTL (nras_pkg and the modules under the top level).
module testbench;

    // Clock, reset and run length.
    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 6;
    localparam int LIMIT_NS     = 24_000_000;

    // Block configuration and protocol codes.
    localparam int         DEPTH      = 32;
    localparam logic [7:0] CMD_MASK   = 8'h80;
    localparam logic [7:0] WRITE_MASK = 8'h40;
    localparam logic [7:0] SPARE_MASK = 8'h20;
    localparam logic [7:0] DATA_MASK  = 8'h7F;
    localparam logic [7:0] LOG_OPEN   = 8'hA0;
    localparam logic [7:0] LOG_CLOSE  = 8'h00;

    // Stimulus shape.
    localparam int ITEM_TARGET = 460;
    localparam int MID_PAUSE   = 230;
    localparam int CALM_TAIL   = 50;
    localparam int HOLD_AT     = 120;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_LIMIT = 20000;
    localparam int END_WAIT    = 40;
    localparam int MAX_PRINTS  = 40;

    // One expected reply byte.
    typedef struct packed
    {
        logic [7:0] data;
        logic       fin;
    } reply_t;

    // One entry of the sender's list: a byte, or a pause until all replies are in.
    typedef struct packed
    {
        logic       drain;
        logic [7:0] data;
    } stim_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] tx_byte;
    logic       last;

    // Shadow state of the block.
    logic [15:0] shadow_mem [0:DEPTH-1];
    logic [4:0]  cur_addr;
    logic [1:0]  nib_count;
    logic [11:0] nib_hold;

    string rd_done_txt = "Read : finish";
    string wr_done_txt = "Write : finish";

    reply_t reply_q [$];
    stim_t  stim_q  [$];

    int err_count   = 0;
    int taken_count = 0;
    int total_items = 0;
    int send_gap    = 0;
    int rcv_left    = 0;
    bit rcv_stall   = 1'b0;
    bit in_taken    = 1'b0;
    bit calm        = 1'b0;
    bit hold_off    = 1'b0;

    nibble_register_access_slave #(.STORE_DEPTH(DEPTH)) uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tx_byte   (tx_byte),
        .last      (last)
    );

    always #(HALF_PERIOD) clk = ~clk;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("ERROR at %0t: %s, got %02h, expected %02h", $time, what, got, want);
    endtask

    task automatic push_reply(input logic [7:0] b, input logic fin);
        reply_t r;
        r.data = b;
        r.fin  = fin;
        reply_q.push_back(r);
    endtask

    // A log frame: opening byte, the text, closing byte; the closing byte ends the run.
    task automatic push_log(input string txt);
        int k;
        push_reply(LOG_OPEN, 1'b0);
        for (k = 0; k < txt.len(); k++)
            push_reply(txt[k], 1'b0);
        push_reply(LOG_CLOSE, 1'b1);
    endtask

    // Advance the shadow state by one received byte and queue the reply bytes it causes.
    task automatic predict_reply(input logic [7:0] b);
        logic [15:0] w;
        int          k;
        if ((b & CMD_MASK) != 8'h00)
        begin
            cur_addr = b[4:0];
            if ((b & WRITE_MASK) != 8'h00)
            begin
                // A write command restarts nibble collection but keeps the held nibbles,
                // which are shifted out by the coming data anyway.
                nib_count = 2'd0;
            end
            else
            begin
                // A read leaves the nibble collection untouched.
                w = (int'(cur_addr) < DEPTH) ? shadow_mem[cur_addr] : 16'h0000;
                push_reply(CMD_MASK | {3'b000, cur_addr}, 1'b0);
                for (k = 3; k >= 0; k--)
                    push_reply({4'h0, w[4*k +: 4]}, 1'b0);
                push_log(rd_done_txt);
            end
        end
        else if (nib_count != 2'd3)
        begin
            // Bits 6..4 of a data byte carry no meaning.
            nib_hold  = {nib_hold[7:0], b[3:0]};
            nib_count = nib_count + 2'd1;
        end
        else
        begin
            w = {nib_hold, b[3:0]};
            if (int'(cur_addr) < DEPTH)
                shadow_mem[cur_addr] = w;
            nib_count = 2'd0;
            nib_hold  = 12'h000;
            push_log(wr_done_txt);
        end
    endtask

    task automatic add_byte(input logic [7:0] b);
        stim_t s;
        s.drain = 1'b0;
        s.data  = b;
        stim_q.push_back(s);
        total_items++;
    endtask

    task automatic add_drain();
        stim_t s;
        s.drain = 1'b1;
        s.data  = 8'h00;
        stim_q.push_back(s);
    endtask

    // Monitor: at each rising edge, check a reply transfer against the oldest expectation,
    // then feed an accepted input transfer to the predictor. Replies pass the job queue and
    // the output register after their input, so checking first keeps the order right.
    always @(posedge clk)
    begin : monitor
        reply_t want;
        in_taken = 1'b0;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (reply_q.size() == 0)
                begin
                    report_mismatch("reply byte with nothing expected", tx_byte, 8'h00);
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (tx_byte !== want.data)
                        report_mismatch("tx_byte", tx_byte, want.data);
                    if (last !== want.fin)
                        report_mismatch("last", {7'b0, last}, {7'b0, want.fin});
                end
            end
            if (in_valid && in_ready)
            begin
                predict_reply(rx_byte);
                taken_count++;
                in_taken = 1'b1;
            end
        end
        // Near the end of the list both sides stop idling.
        calm = (stim_q.size() < CALM_TAIL);
    end

    // Sender: at each falling edge, keep an unaccepted transfer as it is; otherwise take
    // the next entry, unless a burst of idle cycles is running. A pause entry holds the
    // sender until every expected reply byte has arrived.
    always @(negedge clk)
    begin : sender
        stim_t nxt;
        logic  v_next;
        v_next = in_valid;
        if (!rst_n)
        begin
            v_next = 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            v_next = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
            end
            else if (stim_q.size() > 0)
            begin
                nxt = stim_q[0];
                if (nxt.drain)
                begin
                    if (reply_q.size() == 0)
                        nxt = stim_q.pop_front();
                end
                else
                begin
                    nxt = stim_q.pop_front();
                    rx_byte <= nxt.data;
                    v_next = 1'b1;
                    if (!calm && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 19);
                end
            end
        end
        in_valid <= v_next;
    end

    // Receiver: alternating runs of ready and stalled cycles, always ready near the end,
    // never ready while the long hold-off is on.
    always @(negedge clk)
    begin : receiver
        logic r_next;
        if (!rst_n || hold_off)
        begin
            r_next = 1'b0;
        end
        else if (calm)
        begin
            r_next = 1'b1;
        end
        else
        begin
            if (rcv_left == 0)
            begin
                rcv_stall = ($urandom_range(0, 2) == 0);
                rcv_left  = rcv_stall ? $urandom_range(1, 19) : $urandom_range(1, 40);
            end
            rcv_left--;
            r_next = !rcv_stall;
        end
        out_ready <= r_next;
    end

    // Long hold-off on the reply side: the job queue fills and the input must stall.
    initial
    begin : long_hold
        while (taken_count < HOLD_AT)
            @(posedge clk);
        hold_off = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("nibble_register_access_slave test failed");
        $finish;
    end

    initial
    begin : main
        int         i;
        int         n;
        int         kind;
        logic [4:0] a_sel;
        logic [7:0] spare;
        bit         mid_done;

        for (i = 0; i < DEPTH; i++)
            shadow_mem[i] = 16'h0000;
        cur_addr  = 5'd0;
        nib_count = 2'd0;
        nib_hold  = 12'h000;
        mid_done  = 1'b0;

        // Directed part. A read straight after reset sees the cleared store.
        add_byte(CMD_MASK);
        // Data before any write command lands at address zero; high bits of data are ignored.
        add_byte(8'h0F);
        add_byte(8'h7A);
        add_byte(8'h05);
        add_byte(8'h3C);
        add_byte(CMD_MASK);
        // Every bit set: a write command to the top address, then all-ones data.
        add_byte(8'hFF);
        add_byte(8'h0F);
        add_byte(8'h0F);
        add_byte(8'h0F);
        add_byte(8'h0F);
        add_byte(CMD_MASK | SPARE_MASK | 8'h1F);
        // A read in the middle of a write leaves the collected nibbles in place.
        add_byte(CMD_MASK | WRITE_MASK | 8'h05);
        add_byte(8'h01);
        add_byte(8'h02);
        add_byte(CMD_MASK | 8'h05);
        add_byte(8'h03);
        add_byte(8'h64);
        add_byte(CMD_MASK | 8'h05);
        // A second write command restarts collection; a zero nibble goes through too.
        add_byte(CMD_MASK | WRITE_MASK | 8'h03);
        add_byte(8'h09);
        add_byte(CMD_MASK | WRITE_MASK | 8'h03);
        add_byte(8'h00);
        add_byte(8'h5B);
        add_byte(8'h0E);
        add_byte(8'h27);
        add_byte(CMD_MASK | 8'h03);
        add_drain();

        // Random part: mostly complete writes and reads, some cut-short writes and noise.
        // Half the addresses come from a small set so that reads meet written words.
        while (total_items < ITEM_TARGET)
        begin
            if (!mid_done && total_items >= MID_PAUSE)
            begin
                add_drain();
                mid_done = 1'b1;
            end
            kind  = $urandom_range(0, 9);
            a_sel = ($urandom_range(0, 1) == 1) ? 5'($urandom_range(0, 3))
                                                : 5'($urandom_range(0, 31));
            spare = ($urandom_range(0, 1) == 1) ? SPARE_MASK : 8'h00;
            if (kind < 4)
            begin
                add_byte(CMD_MASK | WRITE_MASK | spare | {3'b000, a_sel});
                for (n = 0; n < 4; n++)
                    add_byte(8'($urandom_range(0, 255)) & DATA_MASK);
            end
            else if (kind < 8)
            begin
                add_byte(CMD_MASK | spare | {3'b000, a_sel});
            end
            else if (kind == 8)
            begin
                add_byte(CMD_MASK | WRITE_MASK | spare | {3'b000, a_sel});
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++)
                    add_byte(8'($urandom_range(0, 255)) & DATA_MASK);
            end
            else
            begin
                add_byte(8'($urandom_range(0, 255)));
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every byte to be taken, then for every reply byte to come out.
        while (taken_count < total_items)
            @(posedge clk);
        n = 0;
        while (reply_q.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        // A further wait catches any stray reply byte.
        repeat (END_WAIT) @(posedge clk);
        if (reply_q.size() != 0)
            report_mismatch("reply bytes never sent", 8'h00, 8'(reply_q.size()));

        if (err_count == 0)
            $display("nibble_register_access_slave test passed");
        else
            $display("nibble_register_access_slave test failed");
        $finish;
    end

endmodule

/* nibble_register_access_slave.f */
src/nras_pkg.sv
src/nras_front.sv
src/nras_queue.sv
src/nras_back.sv
src/nibble_register_access_slave.sv
tb/testbench.sv
